// ===== design/upce_pkg.sv =====
// ----------------------------------------------------------------------------
// upce_pkg
// Shared types, constants and code tables for the UPC-E module encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upce_pkg;

	localparam int unsigned QUIET_LENGTH_DEF = 8;
	localparam int unsigned NUM_LONG         = 11;
	localparam int unsigned NUM_SHORT        = 6;
	localparam int unsigned BCD_W            = 44;
	localparam int unsigned PADDR_W          = 3;
	localparam int unsigned PDATA_W          = 32;

	typedef logic [3:0] digit_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIGIT    = 2'd1,
		ERR_NSYS     = 2'd2,
		ERR_COMPRESS = 2'd3
	} err_t;

	// segment index within one symbol
	localparam logic [3:0] SEG_QUIET_HEAD = 4'd0;
	localparam logic [3:0] SEG_START      = 4'd1;
	localparam logic [3:0] SEG_DIGIT0     = 4'd2;
	localparam logic [3:0] SEG_STOP       = 4'd8;
	localparam logic [3:0] SEG_QUIET_TAIL = 4'd9;

	localparam logic [7:0] START_BITS = 8'h05;
	localparam logic [3:0] START_LEN  = 4'd3;
	localparam logic [7:0] STOP_BITS  = 8'h15;
	localparam logic [3:0] STOP_LEN   = 4'd6;
	localparam logic [3:0] DIGIT_LEN  = 4'd7;

	// register addresses (word index)
	localparam logic REG_QUIET = 1'b0;

	// after compression / expansion
	typedef struct packed {
		logic [5:0][3:0]  e;
		logic [10:0][3:0] a;
		logic             ns;
		err_t             err;
	} front_t;

	// after checksum
	typedef struct packed {
		logic [5:0][3:0] e;
		logic [5:0]      par;
		digit_t          chk;
		err_t            err;
	} chk_item_t;

	function automatic logic [6:0] odd_code(input digit_t d);
		logic [6:0] r;
		unique case (d)
			4'd0: r = 7'h0D;
			4'd1: r = 7'h19;
			4'd2: r = 7'h13;
			4'd3: r = 7'h3D;
			4'd4: r = 7'h23;
			4'd5: r = 7'h31;
			4'd6: r = 7'h2F;
			4'd7: r = 7'h3B;
			4'd8: r = 7'h37;
			4'd9: r = 7'h0B;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] even_code(input digit_t d);
		logic [6:0] r;
		unique case (d)
			4'd0: r = 7'h27;
			4'd1: r = 7'h33;
			4'd2: r = 7'h1B;
			4'd3: r = 7'h21;
			4'd4: r = 7'h1D;
			4'd5: r = 7'h39;
			4'd6: r = 7'h05;
			4'd7: r = 7'h11;
			4'd8: r = 7'h09;
			4'd9: r = 7'h17;
			default: r = 7'h00;
		endcase
		return r;
	endfunction

	// bit 5 is the first data digit, 1 = odd parity
	function automatic logic [5:0] parity_pat(input logic ns, input digit_t chk);
		logic [5:0] r;
		unique case (chk)
			4'd0: r = 6'h07;
			4'd1: r = 6'h0B;
			4'd2: r = 6'h0D;
			4'd3: r = 6'h0E;
			4'd4: r = 6'h13;
			4'd5: r = 6'h19;
			4'd6: r = 6'h1C;
			4'd7: r = 6'h15;
			4'd8: r = 6'h16;
			4'd9: r = 6'h1A;
			default: r = 6'h00;
		endcase
		// number system 1 uses the complement pattern
		return ns ? ~r : r;
	endfunction

endpackage

`default_nettype wire

// ===== design/upce_if.sv =====
// ----------------------------------------------------------------------------
// upce_item_if / upce_seg_if
// Valid/ready channels for input numbers and output segments.
// ----------------------------------------------------------------------------
`default_nettype none

interface upce_item_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [43:0] digits_bcd;

	modport source(output valid, output mode, output digits_bcd, input ready);
	modport sink(input valid, input mode, input digits_bcd, output ready);
endinterface

interface upce_seg_if;
	logic       valid;
	logic       ready;
	logic [7:0] segment_bits;
	logic [3:0] segment_length;
	logic [3:0] check_digit;
	logic [1:0] error_code;
	logic       last;

	modport source(output valid, output segment_bits, output segment_length,
		output check_digit, output error_code, output last, input ready);
	modport sink(input valid, input segment_bits, input segment_length,
		input check_digit, input error_code, input last, output ready);
endinterface

`default_nettype wire

// ===== design/upce_front.sv =====
// ----------------------------------------------------------------------------
// upce_front
// Stages 1-2: digit screening, then UPC-A compression or UPC-E expansion.
// ----------------------------------------------------------------------------
`default_nettype none

module upce_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire                in_mode,
	input  wire  [43:0]        in_digits,
	output logic               out_valid,
	input  wire                out_ready,
	output upce_pkg::front_t   out_data
);

	logic        v_s1;
	logic        mode_s1;
	logic [43:0] bcd_s1;
	logic        nd_s1;
	logic        v_s2;
	upce_pkg::front_t data_s2;

	logic adv1, adv2;
	logic nd_in;
	upce_pkg::front_t nxt;

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// non-digit screen on the nibbles in use
	always_comb begin
		nd_in = 1'b0;
		for (int i = 0; i < 11; i++) begin
			if ((i < 6 || in_mode) && (in_digits[4*i +: 4] > 4'd9)) begin
				nd_in = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			mode_s1 <= in_mode;
			bcd_s1  <= in_digits;
			nd_s1   <= nd_in;
		end
	end

	always_comb begin
		logic [10:0][3:0] a;
		logic [5:0][3:0]  e;
		logic             ok, z67;
		a = '0;
		e = '0;
		ok = 1'b1;
		if (mode_s1) begin
			for (int i = 0; i < 11; i++) begin
				a[i] = bcd_s1[4*(10-i) +: 4];
			end
			z67 = (a[6] == 4'd0) && (a[7] == 4'd0);
			priority if (a[5] == 4'd0 && a[4] == 4'd0 && a[3] <= 4'd2) begin
				ok = z67;
				e[0] = a[1]; e[1] = a[2]; e[2] = a[8]; e[3] = a[9]; e[4] = a[10];
				e[5] = a[3];
			end else if (a[5] == 4'd0 && a[4] == 4'd0) begin
				ok = z67 && (a[8] == 4'd0);
				e[0] = a[1]; e[1] = a[2]; e[2] = a[3]; e[3] = a[9]; e[4] = a[10];
				e[5] = 4'd3;
			end else if (a[5] == 4'd0) begin
				ok = z67 && (a[8] == 4'd0) && (a[9] == 4'd0);
				e[0] = a[1]; e[1] = a[2]; e[2] = a[3]; e[3] = a[4]; e[4] = a[10];
				e[5] = 4'd4;
			end else begin
				ok = z67 && (a[8] == 4'd0) && (a[9] == 4'd0) && (a[10] >= 4'd5);
				e[0] = a[1]; e[1] = a[2]; e[2] = a[3]; e[3] = a[4]; e[4] = a[5];
				e[5] = a[10];
			end
		end else begin
			z67 = 1'b0;
			for (int i = 0; i < 6; i++) begin
				e[i] = bcd_s1[4*(5-i) +: 4];
			end
			// expand to UPC-A with number system 0
			a[1] = e[0];
			a[2] = e[1];
			priority if (e[5] <= 4'd2) begin
				a[3] = e[5]; a[8] = e[2]; a[9] = e[3]; a[10] = e[4];
			end else if (e[5] == 4'd3) begin
				a[3] = e[2]; a[9] = e[3]; a[10] = e[4];
			end else if (e[5] == 4'd4) begin
				a[3] = e[2]; a[4] = e[3]; a[10] = e[4];
			end else begin
				a[3] = e[2]; a[4] = e[3]; a[5] = e[4]; a[10] = e[5];
			end
		end
		nxt.a  = a;
		nxt.e  = e;
		nxt.ns = mode_s1 && (a[0] == 4'd1);
		priority if (nd_s1) begin
			nxt.err = upce_pkg::ERR_DIGIT;
		end else if (mode_s1 && a[0] > 4'd1) begin
			nxt.err = upce_pkg::ERR_NSYS;
		end else if (mode_s1 && !ok) begin
			nxt.err = upce_pkg::ERR_COMPRESS;
		end else begin
			nxt.err = upce_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

// ===== design/upce_chk.sv =====
// ----------------------------------------------------------------------------
// upce_chk
// Stages 3-4: weighted digit sum, then modulo 10 and parity pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module upce_chk (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  upce_pkg::front_t     in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output upce_pkg::chk_item_t  out_data
);

	logic                  v_s3;
	logic [5:0][3:0]       e_s3;
	logic                  ns_s3;
	upce_pkg::err_t        err_s3;
	logic [7:0]            sum_s3;
	logic                  v_s4;
	upce_pkg::chk_item_t   data_s4;

	logic       adv3, adv4;
	logic [5:0] s_even, s_odd;
	logic [7:0] sum_nxt;
	logic [15:0] prod;
	logic [4:0]  quo;
	logic [7:0]  rem;
	logic [3:0]  chk_nxt;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign in_ready = adv3;

	// weights 3,1,3,... from the first digit
	always_comb begin
		s_even = '0;
		s_odd  = '0;
		for (int i = 0; i < 11; i += 2) begin
			s_even = s_even + 6'(in_data.a[i]);
		end
		for (int i = 1; i < 11; i += 2) begin
			s_odd = s_odd + 6'(in_data.a[i]);
		end
		sum_nxt = 8'({s_even, 1'b0}) + 8'(s_even) + 8'(s_odd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && in_valid) begin
			e_s3   <= in_data.e;
			ns_s3  <= in_data.ns;
			err_s3 <= in_data.err;
			sum_s3 <= sum_nxt;
		end
	end

	// sum mod 10 by reciprocal, exact for 8-bit sums
	assign prod    = 16'(sum_s3) * 16'd205;
	assign quo     = prod[15:11];
	assign rem     = sum_s3 - 8'({quo, 3'b000}) - 8'({quo, 1'b0});
	assign chk_nxt = (rem == 8'd0) ? 4'd0 : 4'(8'd10 - rem);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			data_s4.e   <= e_s3;
			data_s4.chk <= chk_nxt;
			data_s4.par <= upce_pkg::parity_pat(ns_s3, chk_nxt);
			data_s4.err <= err_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = data_s4;

endmodule

`default_nettype wire

// ===== design/upce_emit.sv =====
// ----------------------------------------------------------------------------
// upce_emit
// Stage 5 and output register: walks one item through its segments.
// ----------------------------------------------------------------------------
`default_nettype none

module upce_emit #(
	parameter int unsigned QUIET_LENGTH = upce_pkg::QUIET_LENGTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  quiet_en,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  upce_pkg::chk_item_t  in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           out_bits,
	output logic [3:0]           out_length,
	output logic [3:0]           out_chk,
	output logic [1:0]           out_err,
	output logic                 out_last
);

	localparam logic [3:0] QLEN = 4'(QUIET_LENGTH);

	typedef logic [3:0] digit_sel_t;

	logic                 v_s5;
	upce_pkg::chk_item_t  item_s5;
	logic [3:0]           idx_q;
	logic                 ov_q;
	logic [7:0]           bits_q;
	logic [3:0]           len_q;
	logic [3:0]           chk_q;
	upce_pkg::err_t       err_q;
	logic                 last_q;

	logic       load_out;
	logic [7:0] seg_bits;
	logic [3:0] seg_len;
	logic       seg_last;
	logic [2:0] dsel;
	digit_sel_t dsel_dummy;

	assign load_out = v_s5 && (!ov_q || out_ready);
	assign in_ready = !v_s5 || (load_out && seg_last);
	assign dsel     = 3'(idx_q - upce_pkg::SEG_DIGIT0);
	assign dsel_dummy = item_s5.e[dsel];

	always_comb begin
		seg_bits = 8'h00;
		seg_len  = 4'd0;
		seg_last = 1'b0;
		if (item_s5.err != upce_pkg::ERR_NONE) begin
			seg_last = 1'b1;
		end else begin
			unique case (idx_q)
				upce_pkg::SEG_QUIET_HEAD: begin
					seg_len = QLEN;
				end
				upce_pkg::SEG_START: begin
					seg_bits = upce_pkg::START_BITS;
					seg_len  = upce_pkg::START_LEN;
				end
				upce_pkg::SEG_STOP: begin
					seg_bits = upce_pkg::STOP_BITS;
					seg_len  = upce_pkg::STOP_LEN;
					seg_last = !quiet_en;
				end
				upce_pkg::SEG_QUIET_TAIL: begin
					seg_len  = QLEN;
					seg_last = 1'b1;
				end
				default: begin
					seg_len  = upce_pkg::DIGIT_LEN;
					seg_bits = item_s5.par[3'd5 - dsel] ?
						{1'b0, upce_pkg::odd_code(dsel_dummy)} :
						{1'b0, upce_pkg::even_code(dsel_dummy)};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5  <= 1'b0;
			idx_q <= upce_pkg::SEG_QUIET_HEAD;
		end else if (in_ready) begin
			v_s5  <= in_valid;
			idx_q <= quiet_en ? upce_pkg::SEG_QUIET_HEAD : upce_pkg::SEG_START;
		end else if (load_out) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s5 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_out) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			bits_q <= seg_bits;
			len_q  <= seg_len;
			chk_q  <= (item_s5.err == upce_pkg::ERR_NONE) ? item_s5.chk : 4'd0;
			err_q  <= item_s5.err;
			last_q <= seg_last;
		end
	end

	assign out_valid  = ov_q;
	assign out_bits   = bits_q;
	assign out_length = len_q;
	assign out_chk    = chk_q;
	assign out_err    = err_q;
	assign out_last   = last_q;

	// an error item leaves as a single empty segment
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && err_q != upce_pkg::ERR_NONE |-> last_q && len_q == 4'd0)
		else $error("error segment not final or not empty");

	// a held item never walks past the trailing quiet zone
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> idx_q <= upce_pkg::SEG_QUIET_TAIL)
		else $error("segment index out of range");

	// a good segment always has modules and a decimal check digit
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && err_q == upce_pkg::ERR_NONE |-> len_q != 4'd0 && chk_q <= 4'd9)
		else $error("bad segment length or check digit");

	// the item register is released only on its final segment
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && load_out && !seg_last |=> v_s5)
		else $error("item dropped before its last segment");

endmodule

`default_nettype wire

// ===== design/upce_barcode_module_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// upce_barcode_module_encoder_unit
// Registers in order: input, compressed form, digit sum, check digit, item, output.
// A number leaves as 10 segments with quiet zones, 8 without, 1 on error;
// the emitter sends one segment a cycle while the output port is ready.
// A new number is taken every cycle while the pipeline ahead has room.
// Reset clears all valid bits and sets quiet_zone_enable to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module upce_barcode_module_encoder_unit #(
	parameter int unsigned QUIET_LENGTH = upce_pkg::QUIET_LENGTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	upce_item_if.sink                        item,
	upce_seg_if.source                       segment,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [upce_pkg::PADDR_W-1:0]     paddr,
	input  wire  [upce_pkg::PDATA_W-1:0]     pwdata,
	output logic [upce_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	logic                 quiet_q;
	logic                 f_valid, f_ready;
	upce_pkg::front_t     f_data;
	logic                 c_valid, c_ready;
	upce_pkg::chk_item_t  c_data;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q <= 1'b1;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == upce_pkg::REG_QUIET) begin
			quiet_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == upce_pkg::REG_QUIET) ?
		{{(upce_pkg::PDATA_W-1){1'b0}}, quiet_q} : '0;

	upce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_mode   (item.mode),
		.in_digits (item.digits_bcd),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	upce_chk u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (c_valid),
		.out_ready (c_ready),
		.out_data  (c_data)
	);

	upce_emit #(
		.QUIET_LENGTH (QUIET_LENGTH)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.quiet_en   (quiet_q),
		.in_valid   (c_valid),
		.in_ready   (c_ready),
		.in_data    (c_data),
		.out_valid  (segment.valid),
		.out_ready  (segment.ready),
		.out_bits   (segment.segment_bits),
		.out_length (segment.segment_length),
		.out_chk    (segment.check_digit),
		.out_err    (segment.error_code),
		.out_last   (segment.last)
	);

endmodule

`default_nettype wire

// ===== tb/upce_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// upce_tb_pkg
// Segment predictor and in-order scoreboard for the UPC-E module encoder.
// Each accepted number is turned into its expected segment list, and each
// segment leaving the block is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
package upce_tb_pkg;

	timeunit 1ns;
	timeprecision 1ps;

	// index 0 is the first digit, which sits in the top nibble
	typedef logic [0:10][3:0] upca_t;
	typedef logic [0:5][3:0]  upce_t;

	typedef struct packed {
		logic [7:0]       bits;
		logic [3:0]       len;
		upce_pkg::digit_t chk;
		upce_pkg::err_t   err;
		logic             last;
	} seg_t;

	localparam logic [0:9][6:0] ODD_SET = {7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23,
		7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B};
	localparam logic [0:9][6:0] EVEN_SET = {7'h27, 7'h33, 7'h1B, 7'h21, 7'h1D,
		7'h39, 7'h05, 7'h11, 7'h09, 7'h17};
	// bit 5 is the first data digit, 1 = odd set
	localparam logic [0:9][5:0] NS0_PAR = {6'h07, 6'h0B, 6'h0D, 6'h0E, 6'h13,
		6'h19, 6'h1C, 6'h15, 6'h16, 6'h1A};
	localparam logic [0:9][5:0] NS1_PAR = {6'h38, 6'h34, 6'h32, 6'h31, 6'h2C,
		6'h26, 6'h23, 6'h2A, 6'h29, 6'h25};

	class symbol_scoreboard;
		seg_t        pending[$];
		bit          quiet_on = 1'b1;
		int unsigned numbers;
		int unsigned rejected;
		int unsigned checked;
		int unsigned faults;

		function void push_seg(logic [7:0] bits, logic [3:0] len, upce_pkg::digit_t chk,
			upce_pkg::err_t err, logic last);
			pending.push_back('{bits, len, chk, err, last});
		endfunction

		function void flag(string what, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				faults++;
				$display("%0d ns: %s mismatch, expected 0x%0h, got 0x%0h",
					$time, what, want, got);
			end
		endfunction

		function void note_number(bit long_form, logic [43:0] bcd);
			upca_t            a;
			upce_t            e;
			upce_pkg::digit_t chk;
			logic [5:0]       par;
			int               n;
			int               i;
			int               sum;
			bit               ns;
			bit               squeezed;
			numbers++;
			n = long_form ? 11 : 6;
			a = bcd;
			e = bcd[23:0];
			for (i = 0; i < n; i++) begin
				if (bcd[4*(n-1-i) +: 4] > 4'd9) begin
					rejected++;
					push_seg(8'h0, 4'd0, 4'd0, upce_pkg::ERR_DIGIT, 1'b1);
					return;
				end
			end
			ns = 1'b0;
			if (long_form) begin
				if (a[0] > 4'd1) begin
					rejected++;
					push_seg(8'h0, 4'd0, 4'd0, upce_pkg::ERR_NSYS, 1'b1);
					return;
				end
				// zero suppression: the last nonzero manufacturer digit picks the form
				if (a[4] == 4'd0 && a[5] == 4'd0 && a[3] <= 4'd2) begin
					squeezed = (a[6:7] == '0);
					e = {a[1], a[2], a[8], a[9], a[10], a[3]};
				end else if (a[4] == 4'd0 && a[5] == 4'd0) begin
					squeezed = (a[6:8] == '0);
					e = {a[1], a[2], a[3], a[9], a[10], 4'd3};
				end else if (a[5] == 4'd0) begin
					squeezed = (a[6:9] == '0);
					e = {a[1], a[2], a[3], a[4], a[10], 4'd4};
				end else begin
					squeezed = (a[6:9] == '0) && (a[10] >= 4'd5);
					e = {a[1:5], a[10]};
				end
				if (!squeezed) begin
					rejected++;
					push_seg(8'h0, 4'd0, 4'd0, upce_pkg::ERR_COMPRESS, 1'b1);
					return;
				end
				ns = a[0][0];
			end else begin
				// rebuild the UPC-A number (number system 0) for the checksum
				if (e[5] <= 4'd2)
					a = {4'd0, e[0:1], e[5], 16'h0, e[2:4]};
				else if (e[5] == 4'd3)
					a = {4'd0, e[0:2], 20'h0, e[3:4]};
				else if (e[5] == 4'd4)
					a = {4'd0, e[0:3], 20'h0, e[4]};
				else
					a = {4'd0, e[0:4], 16'h0, e[5]};
			end
			sum = 0;
			for (i = 0; i < 11; i++)
				sum += a[i] * ((i % 2 == 0) ? 3 : 1);
			chk = upce_pkg::digit_t'((10 - sum % 10) % 10);
			par = ns ? NS1_PAR[chk] : NS0_PAR[chk];
			if (quiet_on)
				push_seg(8'h0, 4'(upce_pkg::QUIET_LENGTH_DEF), chk, upce_pkg::ERR_NONE, 1'b0);
			push_seg(upce_pkg::START_BITS, upce_pkg::START_LEN, chk, upce_pkg::ERR_NONE, 1'b0);
			for (i = 0; i < 6; i++)
				push_seg({1'b0, par[5-i] ? ODD_SET[e[i]] : EVEN_SET[e[i]]},
					upce_pkg::DIGIT_LEN, chk, upce_pkg::ERR_NONE, 1'b0);
			push_seg(upce_pkg::STOP_BITS, upce_pkg::STOP_LEN, chk, upce_pkg::ERR_NONE,
				!quiet_on);
			if (quiet_on)
				push_seg(8'h0, 4'(upce_pkg::QUIET_LENGTH_DEF), chk, upce_pkg::ERR_NONE, 1'b1);
		endfunction

		function void check_segment(seg_t got);
			seg_t want;
			checked++;
			if (pending.size() == 0) begin
				faults++;
				$display("%0d ns: segment with no number pending, bits 0x%0h length %0d",
					$time, got.bits, got.len);
				return;
			end
			want = pending.pop_front();
			flag("segment_bits", want.bits, got.bits);
			flag("segment_length", want.len, got.len);
			flag("check_digit", want.chk, got.chk);
			flag("error_code", want.err, got.err);
			flag("last", want.last, got.last);
		endfunction
	endclass

endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for upce_barcode_module_encoder_unit. Directed numbers, then
// random well-formed and malformed numbers under both quiet-zone settings,
// with random gaps on the input, random back-pressure on the output and one
// long output hold. Every segment is checked against the predicted symbol.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG    = 4000;
	localparam int SETTLE      = 8;
	localparam int PHASE_ITEMS = 140;
	// byte address of the register: word index times four
	localparam logic [upce_pkg::PADDR_W-1:0] QUIET_ADDR = {upce_pkg::REG_QUIET, 2'b00};

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [upce_pkg::PADDR_W-1:0] paddr;
	logic [upce_pkg::PDATA_W-1:0] pwdata;
	logic [upce_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	upce_item_if item_ch();
	upce_seg_if  seg_ch();

	upce_tb_pkg::symbol_scoreboard sb = new();
	upce_tb_pkg::seg_t             seen_seg;
	bit                            hold_req;
	int                            calm_left;
	int                            idle_cycles;

	// mode bit on top, digits below
	logic [44:0] directed[$] = '{
		{1'b0, 44'h00000000000}, {1'b0, 44'h00000999999}, {1'b0, 44'hFFFFF123455},
		{1'b0, 44'h00000654320}, {1'b0, 44'h00000123453}, {1'b0, 44'h00000987654},
		{1'b0, 44'h0000012345F}, {1'b0, 44'hAAAAA000009}, {1'b1, 44'h00000000000},
		{1'b1, 44'h12300000456}, {1'b1, 44'h01250000067}, {1'b1, 44'h14567000008},
		{1'b1, 44'h09876500009}, {1'b1, 44'h11111100005}, {1'b1, 44'h01111100004},
		{1'b1, 44'h01200010345}, {1'b1, 44'h01230000145}, {1'b1, 44'h01234000015},
		{1'b1, 44'h21200000345}, {1'b1, 44'h99999999999}, {1'b1, 44'h5A000000000},
		{1'b1, 44'h0000000000A}, {1'b1, 44'hFFFFFFFFFFF}
	};

	upce_barcode_module_encoder_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.segment (seg_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// output back-pressure, plus one long hold when asked
	initial begin
		int budget;
		int r;
		bit rdy;
		budget = 0;
		rdy = 1'b0;
		seg_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				seg_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (budget == 0) begin
				r = $urandom_range(0, 99);
				rdy = (r < 65);
				if (r < 5)
					budget = $urandom_range(40, 100);
				else if (r < 65)
					budget = $urandom_range(1, 12);
				else if (r < 92)
					budget = $urandom_range(1, 3);
				else if (r < 97)
					budget = $urandom_range(4, 12);
				else
					budget = $urandom_range(20, 60);
			end
			budget--;
			seg_ch.ready <= rdy;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				sb.note_number(item_ch.mode, item_ch.digits_bcd);
			if (seg_ch.valid && seg_ch.ready) begin
				seen_seg = '{seg_ch.segment_bits, seg_ch.segment_length, seg_ch.check_digit,
					upce_pkg::err_t'(seg_ch.error_code), seg_ch.last};
				sb.check_segment(seen_seg);
			end
			if ((item_ch.valid && item_ch.ready) || (seg_ch.valid && seg_ch.ready) || psel)
				idle_cycles = 0;
			else if (++idle_cycles >= WATCHDOG) begin
				$display("watchdog: no transaction for %0d cycles, %0d segments pending",
					WATCHDOG, sb.pending.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_number(bit mode, logic [43:0] bcd);
		int gap;
		int r;
		@(negedge clk);
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 4)
				calm_left = $urandom_range(10, 30);
			gap = (r < 55) ? 0 : (r < 85) ? $urandom_range(1, 3) :
				(r < 96) ? $urandom_range(4, 10) : $urandom_range(20, 60);
		end
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.mode       <= mode;
		item_ch.digits_bcd <= bcd;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic send_random(int count);
		upce_tb_pkg::upca_t a;
		upce_tb_pkg::upce_t e;
		bit                 mode;
		logic [43:0]        bcd;
		int                 r;
		int                 k;
		int                 pos;
		repeat (count) begin
			for (k = 0; k < 11; k++)
				a[k] = 4'($urandom_range(0, 9));
			for (k = 0; k < 6; k++)
				e[k] = 4'($urandom_range(0, 9));
			mode = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 50) begin
				// eleven-digit number for one of the four forms, at times with a nonzero digit put into positions 6 to 9
				a[0] = 4'($urandom_range(0, 1));
				case ($urandom_range(0, 3))
					0: begin
						a[3] = 4'($urandom_range(0, 2));
						a[4:7] = '0;
					end
					1: begin
						a[3] = 4'($urandom_range(3, 9));
						a[4:8] = '0;
					end
					2: begin
						a[4] = 4'($urandom_range(1, 9));
						a[5:9] = '0;
					end
					default: begin
						a[5] = 4'($urandom_range(1, 9));
						a[6:9] = '0;
						a[10] = 4'($urandom_range(5, 9));
					end
				endcase
				if ($urandom_range(0, 5) == 0)
					a[$urandom_range(6, 9)] = 4'($urandom_range(1, 9));
				bcd = a;
			end else if (r < 70) begin
				mode = 1'b0;
				bcd = {20'($urandom()), e};
			end else if (r < 78) begin
				bcd = a;
			end else if (r < 90) begin
				mode = 1'($urandom_range(0, 1));
				bcd = mode ? a : {20'($urandom()), e};
				pos = mode ? $urandom_range(0, 10) : $urandom_range(0, 5);
				bcd[4*pos +: 4] = 4'($urandom_range(10, 15));
			end else begin
				mode = 1'($urandom_range(0, 1));
				bcd = 44'({$urandom(), $urandom()});
			end
			send_number(mode, bcd);
		end
	endtask

	// let every expected segment come out before touching the register
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_access(bit wr, logic [upce_pkg::PDATA_W-1:0] wdata,
		output logic [upce_pkg::PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= wr;
		penable <= 1'b0;
		paddr   <= QUIET_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_quiet(bit on);
		logic [upce_pkg::PDATA_W-1:0] rd;
		apb_access(1'b1, {{(upce_pkg::PDATA_W-1){1'b0}}, on}, rd);
		sb.quiet_on = on;
		apb_access(1'b0, '0, rd);
		sb.flag("quiet_zone_enable readback", on, rd[0]);
	endtask

	initial begin
		logic [upce_pkg::PDATA_W-1:0] rd;
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		item_ch.valid      = 1'b0;
		item_ch.mode       = 1'b0;
		item_ch.digits_bcd = '0;
		hold_req           = 1'b0;
		calm_left          = 0;
		idle_cycles        = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apb_access(1'b0, '0, rd);
		sb.flag("quiet_zone_enable after reset", 8'd1, rd[0]);
		foreach (directed[i])
			send_number(directed[i][44], directed[i][43:0]);
		drain();

		set_quiet(1'b0);
		hold_req = 1'b1;
		send_random(PHASE_ITEMS);
		drain();
		set_quiet(1'b1);
		send_random(PHASE_ITEMS);
		drain();
		set_quiet(1'b0);
		send_random(PHASE_ITEMS);
		drain();

		$display("summary: %0d numbers sent (%0d rejected with an error code), %0d segments compared",
			sb.numbers, sb.rejected, sb.checked);
		$display("summary: quiet zones on and off, output held off %0d cycles once under load",
			HOLD_CYCLES);
		if (sb.faults == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
